// ===== hw/rtl/tss_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tss_pkg: shared types and helpers of the touch sample scaler
// Item formats, configuration set, queue entry and divider helper functions.
// ----------------------------------------------------------------------------
package tss_pkg;

  localparam int unsigned AdcBitsDefault   = 12;
  localparam int unsigned QueueDepthDefault = 2;

  localparam int unsigned SampleShift = 3;
  localparam int unsigned NumW        = 32;
  localparam int unsigned DivCycles   = NumW / 2;
  localparam int unsigned CntW        = $clog2(DivCycles);

  localparam logic [13:0] PressureMax = 14'h3fff;
  localparam logic [15:0] S16MaxCode  = 16'h7fff;
  localparam logic [15:0] S16MinCode  = 16'h8000;

  // configuration register indexes
  typedef enum logic [2:0] {
    RegThreshold = 3'd0,
    RegXRes      = 3'd1,
    RegYRes      = 3'd2,
    RegXCalLow   = 3'd3,
    RegXCalHigh  = 3'd4,
    RegYCalLow   = 3'd5,
    RegYCalHigh  = 3'd6
  } tss_reg_e;

  typedef struct packed {
    logic [15:0] z1_word;
    logic [15:0] z2_word;
    logic [15:0] x_word;
    logic [15:0] y_word;
  } tss_in_t;

  typedef struct packed {
    logic               touched;
    logic signed [15:0] x_screen;
    logic signed [15:0] y_screen;
    logic [13:0]        pressure;
    logic               span_error;
  } tss_out_t;

  typedef struct packed {
    logic [15:0] press_threshold;
    logic [15:0] x_resolution;
    logic [15:0] y_resolution;
    logic [15:0] x_cal_low;
    logic [15:0] x_cal_high;
    logic [15:0] y_cal_low;
    logic [15:0] y_cal_high;
  } tss_cfg_t;

  // classified item as it waits between front and back
  typedef struct packed {
    logic            touched;
    logic [13:0]     pressure;
    logic            x_num_neg;
    logic [NumW-1:0] x_num_mag;
    logic            x_span_neg;
    logic [15:0]     x_span_mag;
    logic            x_zero;
    logic            y_num_neg;
    logic [NumW-1:0] y_num_mag;
    logic            y_span_neg;
    logic [15:0]     y_span_mag;
    logic            y_zero;
  } tss_job_t;

  // restoring divider state: partial remainder and dividend/quotient shifter
  typedef struct packed {
    logic [15:0]     rem;
    logic [NumW-1:0] dvd;
  } tss_div_t;

  function automatic tss_div_t div_step(tss_div_t s, logic [15:0] d);
    logic [16:0] trial;
    tss_div_t    r;
    trial = {s.rem, s.dvd[NumW-1]};
    r.dvd = {s.dvd[NumW-2:0], 1'b0};
    if (trial >= {1'b0, d}) begin
      r.rem    = 16'(trial - {1'b0, d});
      r.dvd[0] = 1'b1;
    end else begin
      r.rem = trial[15:0];
    end
    return r;
  endfunction

  // signed 16-bit saturation of a sign and magnitude quotient
  function automatic logic [15:0] sat_s16(logic neg, logic [NumW-1:0] mag);
    logic [15:0] r;
    if (!neg) begin
      r = (mag > NumW'(32767)) ? S16MaxCode : mag[15:0];
    end else begin
      r = (mag > NumW'(32768)) ? S16MinCode : 16'(~mag[15:0] + 16'd1);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/tss_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tss_front: input stage of the touch sample scaler
// Takes readouts, works out pressure and the touch decision, and forms the
// signed numerators and spans of both axes for the divider.
// ----------------------------------------------------------------------------
module tss_front import tss_pkg::*; #(
  parameter int unsigned ADC_BITS = AdcBitsDefault
) (
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire tss_in_t  in_data_i,
  input  wire tss_cfg_t cfg_i,
  input  wire logic     q_full_i,
  output logic          q_push_o,
  output tss_job_t      job_o
);

  localparam logic [16:0] FullScale = 17'((1 << ADC_BITS) - 1);

  logic [12:0]        z1, z2, xs, ys;
  logic signed [17:0] z_raw;
  logic [16:0]        z_abs;
  logic signed [17:0] x_diff, y_diff;
  logic signed [34:0] x_prod, y_prod;
  logic [34:0]        x_prod_abs, y_prod_abs;
  logic signed [16:0] x_span, y_span;
  logic [16:0]        x_span_abs, y_span_abs;

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    z1 = in_data_i.z1_word[15:SampleShift];
    z2 = in_data_i.z2_word[15:SampleShift];
    xs = in_data_i.x_word[15:SampleShift];
    ys = in_data_i.y_word[15:SampleShift];

    z_raw = $signed({1'b0, FullScale}) - $signed({5'd0, z2}) + $signed({5'd0, z1});
    z_abs = z_raw[17] ? 17'(-z_raw) : z_raw[16:0];

    // (raw - low) * resolution, kept as sign and magnitude
    x_diff = $signed({5'd0, xs}) - $signed({2'd0, cfg_i.x_cal_low});
    y_diff = $signed({5'd0, ys}) - $signed({2'd0, cfg_i.y_cal_low});
    x_prod = x_diff * $signed({1'b0, cfg_i.x_resolution});
    y_prod = y_diff * $signed({1'b0, cfg_i.y_resolution});
    x_prod_abs = x_prod[34] ? 35'(-x_prod) : x_prod;
    y_prod_abs = y_prod[34] ? 35'(-y_prod) : y_prod;

    x_span = $signed({1'b0, cfg_i.x_cal_high}) - $signed({1'b0, cfg_i.x_cal_low});
    y_span = $signed({1'b0, cfg_i.y_cal_high}) - $signed({1'b0, cfg_i.y_cal_low});
    x_span_abs = x_span[16] ? 17'(-x_span) : x_span;
    y_span_abs = y_span[16] ? 17'(-y_span) : y_span;

    job_o.touched    = z_abs > {1'b0, cfg_i.press_threshold};
    job_o.pressure   = (z_abs > {3'd0, PressureMax}) ? PressureMax : z_abs[13:0];
    job_o.x_num_neg  = x_prod[34];
    job_o.x_num_mag  = x_prod_abs[NumW-1:0];
    job_o.x_span_neg = x_span[16];
    job_o.x_span_mag = x_span_abs[15:0];
    job_o.x_zero     = (x_span == 17'sd0);
    job_o.y_num_neg  = y_prod[34];
    job_o.y_num_mag  = y_prod_abs[NumW-1:0];
    job_o.y_span_neg = y_span[16];
    job_o.y_span_mag = y_span_abs[15:0];
    job_o.y_zero     = (y_span == 17'sd0);
  end

endmodule
`default_nettype wire

// ===== hw/rtl/tss_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tss_fifo: short queue between front and back
// Register-based first-in first-out buffer of classified items.
// ----------------------------------------------------------------------------
module tss_fifo import tss_pkg::*; #(
  parameter int unsigned DEPTH = QueueDepthDefault
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire tss_job_t push_data_i,
  output logic          full_o,
  input  wire logic     pop_i,
  output logic          empty_o,
  output tss_job_t      pop_data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FillW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

  tss_job_t         mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic             do_push, do_pop;

  assign full_o     = (fill_q == FillW'(DEPTH));
  assign empty_o    = (fill_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : PtrW'(wr_ptr_q + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : PtrW'(rd_ptr_q + 1'b1);
    end
    if (do_push && !do_pop) begin
      fill_d = FillW'(fill_q + 1'b1);
    end else if (do_pop && !do_push) begin
      fill_d = FillW'(fill_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/tss_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tss_back: scaling stage of the touch sample scaler
// Divides both axis numerators by their spans on one shared radix-4
// restoring divider, saturates, and holds the result in the output register.
// ----------------------------------------------------------------------------
module tss_back import tss_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     job_valid_i,
  input  wire tss_job_t job_i,
  output logic          job_pop_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output tss_out_t      out_data_o
);

  typedef enum logic [3:0] {
    BkIdle = 4'b0001,
    BkDivX = 4'b0010,
    BkDivY = 4'b0100,
    BkEmit = 4'b1000
  } tss_bk_state_e;

  tss_bk_state_e   state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  tss_job_t        job_q, job_d;
  tss_div_t        div_q, div_d, step1, step2;
  logic [15:0]     x_q, x_d, y_q, y_d;
  tss_out_t        out_q, out_d;
  logic [15:0]     divisor;
  logic            last_step, out_free;
  logic [15:0]     x_sat, y_sat;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    divisor   = (state_q == BkDivY) ? job_q.y_span_mag : job_q.x_span_mag;
    step1     = div_step(div_q, divisor);
    step2     = div_step(step1, divisor);
    last_step = (cnt_q == CntW'(DivCycles - 1));
    out_free  = !out_valid_q || out_ready_i;
    // a zero span leaves the coordinate at zero
    x_sat = job_q.x_zero ? 16'd0 :
            sat_s16(job_q.x_num_neg ^ job_q.x_span_neg, step2.dvd);
    y_sat = job_q.y_zero ? 16'd0 :
            sat_s16(job_q.y_num_neg ^ job_q.y_span_neg, step2.dvd);

    state_d     = state_q;
    cnt_d       = cnt_q;
    job_d       = job_q;
    div_d       = div_q;
    x_d         = x_q;
    y_d         = y_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    job_pop_o   = 1'b0;

    unique case (state_q)
      BkIdle: begin
        job_pop_o = job_valid_i;
        if (job_valid_i) begin
          job_d     = job_i;
          div_d.rem = '0;
          div_d.dvd = job_i.x_num_mag;
          cnt_d     = '0;
          x_d       = '0;
          y_d       = '0;
          state_d   = job_i.touched ? BkDivX : BkEmit;
        end
      end
      BkDivX: begin
        div_d = step2;
        cnt_d = CntW'(cnt_q + 1'b1);
        if (last_step) begin
          x_d       = x_sat;
          div_d.rem = '0;
          div_d.dvd = job_q.y_num_mag;
          cnt_d     = '0;
          state_d   = BkDivY;
        end
      end
      BkDivY: begin
        div_d = step2;
        cnt_d = CntW'(cnt_q + 1'b1);
        if (last_step) begin
          y_d     = y_sat;
          state_d = BkEmit;
        end
      end
      BkEmit: begin
        if (out_free) begin
          out_d.touched    = job_q.touched;
          out_d.x_screen   = $signed(x_q);
          out_d.y_screen   = $signed(y_q);
          out_d.pressure   = job_q.pressure;
          out_d.span_error = job_q.touched && (job_q.x_zero || job_q.y_zero);
          out_valid_d      = 1'b1;
          state_d          = BkIdle;
        end
      end
      default: begin
        state_d = BkIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BkIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    div_q <= div_d;
    x_q   <= x_d;
    y_q   <= y_d;
    out_q <= out_d;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/touch_sample_scaler.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// touch_sample_scaler: resistive touch panel sample calibration
// Turns one four-word touch controller readout into pressure, touch state and
// calibrated screen coordinates.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (valid/ready) takes one readout item: z1, z2, x and y words.
//   out channel (valid/ready) gives exactly one result item per readout, in
//   order: touched, x_screen, y_screen, pressure, span_error.
//   cfg port writes threshold, resolutions and calibration points; write it
//   only while no item is in flight. Index 7 is ignored.
// Processing:
//   a touched item is loaded from the queue, runs through the shared
//   two-bit-per-cycle divider (x then y) and then fills the output register.
//   A released item skips the divider. The back end takes the next item
//   from the queue only after the last one has filled the output register.
// Reset and stalls:
//   reset empties the queue, drops out_valid and loads the register defaults.
//   When the receiver stalls, the result holds in the output register while
//   the queue keeps taking new items until it fills; then in_ready drops.
// ----------------------------------------------------------------------------
module touch_sample_scaler import tss_pkg::*; #(
  parameter int unsigned ADC_BITS    = AdcBitsDefault,
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire tss_in_t     in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output tss_out_t         out_data_o,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);

  tss_cfg_t cfg_q, cfg_d;
  tss_job_t push_job, pop_job;
  logic     q_full, q_empty, q_push, q_pop;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (tss_reg_e'(cfg_idx_i))
        RegThreshold: cfg_d.press_threshold = cfg_data_i;
        RegXRes:      cfg_d.x_resolution    = cfg_data_i;
        RegYRes:      cfg_d.y_resolution    = cfg_data_i;
        RegXCalLow:   cfg_d.x_cal_low       = cfg_data_i;
        RegXCalHigh:  cfg_d.x_cal_high      = cfg_data_i;
        RegYCalLow:   cfg_d.y_cal_low       = cfg_data_i;
        RegYCalHigh:  cfg_d.y_cal_high      = cfg_data_i;
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.press_threshold <= 16'd0;
      cfg_q.x_resolution    <= 16'd320;
      cfg_q.y_resolution    <= 16'd240;
      cfg_q.x_cal_low       <= 16'd0;
      cfg_q.x_cal_high      <= 16'd320;
      cfg_q.y_cal_low       <= 16'd0;
      cfg_q.y_cal_high      <= 16'd240;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  tss_front #(
    .ADC_BITS(ADC_BITS)
  ) u_front (
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i (in_data_i),
    .cfg_i     (cfg_q),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .job_o     (push_job)
  );

  tss_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_data_i(push_job),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .pop_data_o (pop_job)
  );

  tss_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(!q_empty),
    .job_i      (pop_job),
    .job_pop_o  (q_pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/tss_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tss_checker: port-level checks of the touch sample scaler
// Watches the item channels and flags ordering and content slips.
// ----------------------------------------------------------------------------
module tss_checker import tss_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire tss_out_t    out_data_o
);

  logic [7:0] pending_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // items taken but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_acc && !out_acc) begin
      pending_q <= pending_q + 8'd1;
    end else if (out_acc && !in_acc) begin
      pending_q <= pending_q - 8'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result item changed while stalled");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != 8'd0)
    else $error("result item without an accepted readout");

  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q == 8'd0 |-> in_ready_o)
    else $error("input stalled while nothing is in flight");

  a_release_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.touched |->
      out_data_o.x_screen == 16'sd0 && out_data_o.y_screen == 16'sd0 &&
      !out_data_o.span_error)
    else $error("released item carries coordinates or span error");

endmodule

bind touch_sample_scaler tss_checker u_tss_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);
`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: touch sample scaler testbench
// Feeds touch readouts through the valid/ready input with random gaps and a
// randomly stalling sink, predicts touch state, pressure and calibrated
// coordinates in a shadow model, and compares every result in order.
// ----------------------------------------------------------------------------
module tb;
  import tss_pkg::*;

  localparam int          FullScale   = (1 << AdcBitsDefault) - 1;
  localparam int          SettleCycles = 40;
  localparam int          HoldCycles  = 400;
  localparam int          PhaseItems  = 150;
  localparam int          NumPhases   = 7;
  localparam longint      CycleLimit  = 1000000;
  localparam logic [2:0]  RegIgnored  = 3'd7;

  typedef struct {
    bit          is_cfg;
    logic [2:0]  reg_idx;
    logic [15:0] reg_val;
    tss_in_t     readout;
    bit          typed;
    tss_out_t    want;
  } bringup_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_ready_o;
  tss_in_t     in_data;
  logic        out_valid_o;
  logic        out_ready;
  tss_out_t    out_data_o;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [15:0] cfg_data;

  tss_cfg_t     shadow_cfg;
  bit           shadow_pressed;
  tss_out_t     pending_results[$];
  int           outstanding;
  int           mismatch_count;
  longint       cycle_count;
  bit           steady_source;
  bit           steady_sink;
  int           hold_requests;
  int           hold_served;
  bringup_row_t bringup_plan[$];

  touch_sample_scaler dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // one axis: (raw - lo) * res / (hi - lo), truncated, saturated to s16
  function automatic logic [15:0] scale_coord(logic [12:0] raw, logic [15:0] lo,
                                              logic [15:0] hi, logic [15:0] res,
                                              output bit zero_span);
    longint span;
    longint quo;
    span      = longint'(hi) - longint'(lo);
    zero_span = (span == 0);
    if (zero_span) return 16'h0000;
    quo = ((longint'(raw) - longint'(lo)) * longint'(res)) / span;
    if (quo > 32767) quo = 32767;
    if (quo < -32768) quo = -32768;
    return quo[15:0];
  endfunction

  function automatic tss_out_t calibrate_readout(tss_in_t rd);
    tss_out_t r;
    int       z;
    bit       x_bad;
    bit       y_bad;
    r     = '0;
    x_bad = 1'b0;
    y_bad = 1'b0;
    z = FullScale - int'(rd.z2_word >> SampleShift) + int'(rd.z1_word >> SampleShift);
    if (z < 0) z = -z;
    shadow_pressed = (z > int'(shadow_cfg.press_threshold));
    if (shadow_pressed) begin
      r.x_screen = scale_coord(13'(rd.x_word >> SampleShift), shadow_cfg.x_cal_low,
                               shadow_cfg.x_cal_high, shadow_cfg.x_resolution, x_bad);
      r.y_screen = scale_coord(13'(rd.y_word >> SampleShift), shadow_cfg.y_cal_low,
                               shadow_cfg.y_cal_high, shadow_cfg.y_resolution, y_bad);
      r.span_error = x_bad | y_bad;
    end
    r.touched  = shadow_pressed;
    r.pressure = (z > 16383) ? PressureMax : 14'(z);
    return r;
  endfunction

  // mostly short idles, a few long ones
  function automatic int unsigned pick_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 3);
    if (r < 92) return $urandom_range(4, 16);
    return $urandom_range(30, 90);
  endfunction

  // half fully random words, half with pressure right around the threshold
  function automatic tss_in_t make_readout();
    tss_in_t rd;
    int      target;
    int      z2_lo;
    int      z2_hi;
    int      z2s;
    rd = {$urandom(), $urandom()};
    if ($urandom_range(0, 1) == 1) begin
      target = int'(shadow_cfg.press_threshold) + int'($urandom_range(0, 6)) - 3;
      if (target < 0) target = 0;
      if (target > 12286) target = 12286;
      z2_lo = (target >= FullScale) ? 0 : FullScale - target;
      z2_hi = (target <= FullScale) ? 8191 : 8191 + FullScale - target;
      z2s   = int'($urandom_range(z2_lo, z2_hi));
      rd.z2_word = {13'(z2s), rd.z2_word[2:0]};
      rd.z1_word = {13'(target - FullScale + z2s), rd.z1_word[2:0]};
    end
    return rd;
  endfunction

  function automatic bringup_row_t cfg_row(logic [2:0] idx, logic [15:0] val);
    bringup_row_t row;
    row         = '{default: '0};
    row.is_cfg  = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  function automatic bringup_row_t item_row(logic [15:0] z1, logic [15:0] z2,
                                            logic [15:0] x, logic [15:0] y);
    bringup_row_t row;
    row         = '{default: '0};
    row.readout = '{z1_word: z1, z2_word: z2, x_word: x, y_word: y};
    return row;
  endfunction

  function automatic bringup_row_t known_row(logic [15:0] z1, logic [15:0] z2,
                                             logic [15:0] x, logic [15:0] y, logic t,
                                             logic [15:0] xs, logic [15:0] ys,
                                             logic [13:0] p, logic err);
    bringup_row_t row;
    row       = item_row(z1, z2, x, y);
    row.typed = 1'b1;
    row.want  = '{touched: t, x_screen: xs, y_screen: ys, pressure: p, span_error: err};
    return row;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    case (idx)
      RegThreshold: shadow_cfg.press_threshold = val;
      RegXRes:      shadow_cfg.x_resolution    = val;
      RegYRes:      shadow_cfg.y_resolution    = val;
      RegXCalLow:   shadow_cfg.x_cal_low       = val;
      RegXCalHigh:  shadow_cfg.x_cal_high      = val;
      RegYCalLow:   shadow_cfg.y_cal_low       = val;
      RegYCalHigh:  shadow_cfg.y_cal_high      = val;
      default: ;
    endcase
  endtask

  // valid is left high after acceptance so back-to-back items need no toggle
  task automatic offer_readout(tss_in_t rd, bit typed, tss_out_t want);
    int unsigned gap;
    tss_out_t    predicted;
    cfg_we <= 1'b0;
    gap = steady_source ? 0 : (($urandom_range(0, 99) < 50) ? 0 : pick_idle());
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= rd;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predicted = calibrate_readout(rd);
    pending_results.push_back(typed ? want : predicted);
    outstanding++;
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    wait (outstanding == 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic check_result(tss_out_t got);
    tss_out_t want;
    if (outstanding == 0) begin
      $error("result with no expectation waiting");
      mismatch_count++;
    end else begin
      want = pending_results.pop_front();
      outstanding--;
      if (got.touched !== want.touched) begin
        $error("touched: expected %0d, got %0d", want.touched, got.touched);
        mismatch_count++;
      end
      if (got.x_screen !== want.x_screen) begin
        $error("x_screen: expected %0d, got %0d", want.x_screen, got.x_screen);
        mismatch_count++;
      end
      if (got.y_screen !== want.y_screen) begin
        $error("y_screen: expected %0d, got %0d", want.y_screen, got.y_screen);
        mismatch_count++;
      end
      if (got.pressure !== want.pressure) begin
        $error("pressure: expected %0d, got %0d", want.pressure, got.pressure);
        mismatch_count++;
      end
      if (got.span_error !== want.span_error) begin
        $error("span_error: expected %0d, got %0d", want.span_error, got.span_error);
        mismatch_count++;
      end
    end
  endtask

  // result sink: random stalls, plus one long hold-off on request
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    hold_served = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready) check_result(out_data_o);
      if (hold_served < hold_requests) begin
        hold_served++;
        stall_left = HoldCycles;
      end
      if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (!steady_sink && $urandom_range(0, 99) < 25) stall_left = pick_idle();
      end
    end
  end

  initial begin
    tss_cfg_t     phase_cfg;
    bringup_row_t row;
    bit           idle_now;

    rst_ni   <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    cfg_we   <= 1'b0;
    cfg_idx  <= RegThreshold;
    cfg_data <= '0;
    shadow_cfg = '{press_threshold: 16'd0, x_resolution: 16'd320, y_resolution: 16'd240,
                   x_cal_low: 16'd0, x_cal_high: 16'd320, y_cal_low: 16'd0,
                   y_cal_high: 16'd240};
    shadow_pressed = 1'b0;
    outstanding    = 0;
    mismatch_count = 0;
    hold_requests  = 0;
    steady_source  = 1'b0;
    steady_sink    = 1'b0;

    // defaults map raw x and y one to one onto the screen
    bringup_plan.push_back(known_row(16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                     1'b1, 16'd0, 16'd0, 14'd4095, 1'b0));
    bringup_plan.push_back(known_row(16'h0000, 16'hffff, 16'hffff, 16'hffff,
                                     1'b1, 16'd8191, 16'd8191, 14'd4096, 1'b0));
    bringup_plan.push_back(known_row(16'hffff, 16'h0000, 16'h0007, 16'h0007,
                                     1'b1, 16'd0, 16'd0, 14'd12286, 1'b0));
    // pressure exactly at threshold is a release
    bringup_plan.push_back(known_row(16'h0000, 16'h7ff8, 16'hffff, 16'hffff,
                                     1'b0, 16'd0, 16'd0, 14'd0, 1'b0));
    bringup_plan.push_back(item_row(16'h0000, 16'h7ff0, 16'h0320, 16'h0190));
    // zero x span
    bringup_plan.push_back(cfg_row(RegXCalHigh, 16'h0000));
    bringup_plan.push_back(known_row(16'h0000, 16'h0000, 16'h0320, 16'h0190,
                                     1'b1, 16'd0, 16'd50, 14'd4095, 1'b1));
    // out-of-range index must not touch any register
    bringup_plan.push_back(cfg_row(RegIgnored, 16'h0140));
    bringup_plan.push_back(known_row(16'h0000, 16'h0000, 16'h0320, 16'h0190,
                                     1'b1, 16'd0, 16'd50, 14'd4095, 1'b1));
    // saturation both ways
    bringup_plan.push_back(cfg_row(RegXCalHigh, 16'h0001));
    bringup_plan.push_back(cfg_row(RegXRes, 16'hffff));
    bringup_plan.push_back(known_row(16'h0000, 16'h0000, 16'hfff8, 16'h0000,
                                     1'b1, S16MaxCode, 16'd0, 14'd4095, 1'b0));
    bringup_plan.push_back(cfg_row(RegXCalLow, 16'h0002));
    bringup_plan.push_back(known_row(16'h0000, 16'h0000, 16'hfff8, 16'h0000,
                                     1'b1, S16MinCode, 16'd0, 14'd4095, 1'b0));
    bringup_plan.push_back(item_row(16'h0000, 16'h0000, 16'h0000, 16'h0000));
    // truncation toward zero on a negative quotient
    bringup_plan.push_back(cfg_row(RegXCalLow, 16'd100));
    bringup_plan.push_back(cfg_row(RegXCalHigh, 16'd103));
    bringup_plan.push_back(cfg_row(RegXRes, 16'd1));
    bringup_plan.push_back(item_row(16'h0000, 16'h0000, 16'h0318, 16'h0000));
    bringup_plan.push_back(item_row(16'h0000, 16'h0000, 16'h0308, 16'h0000));
    bringup_plan.push_back(cfg_row(RegThreshold, 16'hffff));
    bringup_plan.push_back(known_row(16'hffff, 16'h0000, 16'hffff, 16'hffff,
                                     1'b0, 16'd0, 16'd0, 14'd12286, 1'b0));
    bringup_plan.push_back(cfg_row(RegThreshold, 16'd12285));
    bringup_plan.push_back(item_row(16'hfff8, 16'h0008, 16'h1234, 16'h4321));
    bringup_plan.push_back(item_row(16'hffff, 16'h0000, 16'h1234, 16'h4321));
    bringup_plan.push_back(cfg_row(RegThreshold, 16'd0));
    bringup_plan.push_back(cfg_row(RegYRes, 16'h0000));
    bringup_plan.push_back(item_row(16'h0000, 16'h0000, 16'h0000, 16'hffff));
    bringup_plan.push_back(cfg_row(RegYRes, 16'hffff));
    bringup_plan.push_back(cfg_row(RegYCalLow, 16'hffff));
    bringup_plan.push_back(cfg_row(RegYCalHigh, 16'h0000));
    bringup_plan.push_back(item_row(16'h0000, 16'h0000, 16'h0000, 16'hffff));
    bringup_plan.push_back(item_row(16'h0000, 16'h7ff8, 16'h0000, 16'hffff));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_now = 1'b1;
    foreach (bringup_plan[i]) begin
      row = bringup_plan[i];
      if (row.is_cfg) begin
        if (!idle_now) quiesce();
        idle_now = 1'b1;
        write_reg(row.reg_idx, row.reg_val);
      end else begin
        offer_readout(row.readout, row.typed, row.want);
        idle_now = 1'b0;
      end
    end
    quiesce();

    for (int p = 0; p < NumPhases; p++) begin
      if (p == 0) begin
        phase_cfg = '{press_threshold: 16'h0000, x_resolution: 16'hffff,
                      y_resolution: 16'hffff, x_cal_low: 16'h0000, x_cal_high: 16'hffff,
                      y_cal_low: 16'hffff, y_cal_high: 16'h0000};
      end else if (p == NumPhases - 1) begin
        // a zero y span and a zero x resolution
        phase_cfg.press_threshold = 16'($urandom_range(0, 4095));
        phase_cfg.x_resolution    = 16'h0000;
        phase_cfg.y_resolution    = 16'($urandom());
        phase_cfg.x_cal_low       = 16'($urandom());
        phase_cfg.x_cal_high      = 16'($urandom());
        phase_cfg.y_cal_low       = 16'($urandom_range(0, 8191));
        phase_cfg.y_cal_high      = phase_cfg.y_cal_low;
      end else if (p % 2 == 1) begin
        // panel-like calibration, sometimes mirrored on y
        phase_cfg.press_threshold = 16'($urandom_range(0, 3000));
        phase_cfg.x_resolution    = 16'($urandom_range(1, 1920));
        phase_cfg.y_resolution    = 16'($urandom_range(1, 1080));
        phase_cfg.x_cal_low       = 16'($urandom_range(0, 1200));
        phase_cfg.x_cal_high      = 16'($urandom_range(6500, 8191));
        phase_cfg.y_cal_low       = 16'($urandom_range(0, 1200));
        phase_cfg.y_cal_high      = 16'($urandom_range(6500, 8191));
        if ($urandom_range(0, 2) == 0) begin
          phase_cfg.y_cal_low  = 16'($urandom_range(6500, 8191));
          phase_cfg.y_cal_high = 16'($urandom_range(0, 1200));
        end
      end else begin
        phase_cfg = tss_cfg_t'({$urandom(), $urandom(), $urandom(), 16'($urandom())});
        phase_cfg.press_threshold = 16'($urandom_range(0, 13000));
      end
      write_reg(RegThreshold, phase_cfg.press_threshold);
      write_reg(RegXRes,      phase_cfg.x_resolution);
      write_reg(RegYRes,      phase_cfg.y_resolution);
      write_reg(RegXCalLow,   phase_cfg.x_cal_low);
      write_reg(RegXCalHigh,  phase_cfg.x_cal_high);
      write_reg(RegYCalLow,   phase_cfg.y_cal_low);
      write_reg(RegYCalHigh,  phase_cfg.y_cal_high);

      for (int k = 0; k < PhaseItems; k++) begin
        if (k % 50 == 0) begin
          steady_source = ($urandom_range(0, 3) == 0);
          steady_sink   = ($urandom_range(0, 3) == 0);
        end
        // sink holds off while items keep coming, so the block backs up
        if (p == 2 && k == 20) begin
          steady_source = 1'b1;
          hold_requests++;
        end
        if (p == 4 && k == 75) quiesce();
        offer_readout(make_readout(), 1'b0, '0);
      end
      quiesce();
    end

    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
